FILE: src/rmts_pkg.sv
package rmts_pkg;

  localparam int PID_W = 22;
  localparam int PER_W = 16;
  localparam int UTIL_W = 14;
  localparam int TIME_W = 32;
  localparam int BOUND_W = 14;
  localparam int STAT_W = 3;
  localparam logic [BOUND_W-1:0] BOUND_RESET = 14'd6930;
  localparam logic [UTIL_W-1:0] UTIL_MAX = 14'd16383;
  localparam logic [13:0] UTIL_SCALE = 14'd10000;

  typedef enum logic [1:0] {
    ACT_REGISTER = 2'd0,
    ACT_YIELD = 2'd1,
    ACT_DEREGISTER = 2'd2,
    ACT_TICK = 2'd3
  } action_t;

  typedef enum logic [2:0] {
    ST_OK = 3'd0,
    ST_ADMIT_FAIL = 3'd1,
    ST_FULL = 3'd2,
    ST_UNKNOWN = 3'd3,
    ST_ZERO_PERIOD = 3'd4,
    ST_DUPLICATE = 3'd5
  } status_t;

  typedef enum logic [1:0] {
    MODE_READY = 2'd0,
    MODE_RUNNING = 2'd1,
    MODE_SLEEPING = 2'd2
  } mode_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_SCAN_ISSUE,
    S_SCAN,
    S_DIV,
    S_REG_DONE,
    S_ACT,
    S_DISP_ISSUE,
    S_DISP,
    S_DISP_RUNRD,
    S_DISP_DECIDE,
    S_PID_RD,
    S_PID_WAIT,
    S_OUT
  } fsm_t;

  typedef struct packed {
    logic [PID_W-1:0] pid;
    logic [PER_W-1:0] period;
    logic [UTIL_W-1:0] util;
    logic [TIME_W-1:0] deadline;
    logic started;
  } entry_t;

endpackage

FILE: src/rmts_div.sv
module rmts_div (
  input  logic clk,
  input  logic rst,
  input  logic start,
  input  logic [29:0] dividend,
  input  logic [15:0] divisor,
  output logic busy,
  output logic [29:0] quotient
);
  import rmts_pkg::*;

  logic [4:0] count;
  logic [16:0] rem;
  logic [29:0] quo;
  logic [16:0] trial;

  assign trial = {rem[15:0], quo[29]} - {1'b0, divisor};
  assign quotient = quo;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      count <= '0;
    end else if (start) begin
      busy <= 1'b1;
      count <= 5'd29;
      rem <= '0;
      quo <= dividend;
    end else if (busy) begin
      if (!trial[16]) begin
        rem <= trial;
        quo <= {quo[28:0], 1'b1};
      end else begin
        rem <= {rem[15:0], quo[29]};
        quo <= {quo[28:0], 1'b0};
      end
      if (count == '0) begin
        busy <= 1'b0;
      end else begin
        count <= count - 5'd1;
      end
    end
  end

endmodule

FILE: src/rate_monotonic_task_scheduler.sv
// Rate-monotonic task scheduler with a task table held in a synchronous memory.
// Input beats on s_axis carry a command: register, yield, deregister or one time
// tick. Every input beat produces exactly one output beat on m_axis with the
// status, the running task and any switch or preemption that dispatch caused.
// The user writes the admission bound through cfg_we/cfg_data only while the
// block is idle; the block itself does not enforce this. One item is handled at
// a time. A command walks the table one slot per cycle. The result is loaded into
// the output register once that walk ends for a tick or a registration rejected
// before the divide; yield and deregister first read the task's entry. A dispatch
// walks the table again and reads the running task's entry, and a registration
// that passes the slot checks first runs the bit-serial divide of the utilization.
// The next command is accepted in the cycle after its predecessor's result is
// loaded. When the receiver stalls, the held result stays in the output register,
// the next result waits in the block and s_axis_tready stays low until it moves.
// Reset empties the table, clears time and the running task and restores the
// bound to 6930; no clearing pass is needed since per-slot valid and timer bits
// live in flip-flops.
module rate_monotonic_task_scheduler #(
  parameter int MAX_TASKS = 16
) (
  input  logic clk,
  input  logic rst,
  input  logic s_axis_tvalid,
  output logic s_axis_tready,
  // action[1:0], pid[23:2], period[39:24], exec_time[55:40]
  input  logic [55:0] s_axis_tdata,
  output logic m_axis_tvalid,
  input  logic m_axis_tready,
  // status[2:0], deadline_missed[3], run_valid[4], run_pid[26:5], switched[27],
  // preempted_valid[28], preempted_pid[50:29]
  output logic [55:0] m_axis_tdata,
  input  logic cfg_we,
  input  logic [13:0] cfg_data
);
  import rmts_pkg::*;

  localparam int SW = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
  localparam int CW = SW + 1;

  fsm_t state, state_next;

  entry_t mem [MAX_TASKS];
  logic [SW-1:0] rd_addr;
  entry_t rd_data;
  logic wr_en;
  logic [SW-1:0] wr_addr;
  entry_t wr_data;

  logic [MAX_TASKS-1:0] slot_valid;
  logic [MAX_TASKS-1:0] timer_armed;
  logic [1:0] mode [MAX_TASKS];

  logic [BOUND_W-1:0] util_bound;
  logic [TIME_W-1:0] now_ticks;
  logic [SW-1:0] running_slot;
  logic running_valid;
  logic [PID_W-1:0] running_pid;

  logic [1:0] act;
  logic [PID_W-1:0] in_pid;
  logic [PER_W-1:0] in_period;
  logic [PER_W-1:0] in_ptime;

  logic [CW-1:0] cnt;
  logic [SW-1:0] cur;
  logic found;
  logic [SW-1:0] found_slot;
  logic free_found;
  logic [SW-1:0] free_slot;
  logic [18:0] util_sum;
  logic woke;
  logic best_v;
  logic [SW-1:0] best;
  logic [PER_W-1:0] best_period;
  logic [PID_W-1:0] best_pid;

  logic [STAT_W-1:0] o_status;
  logic o_missed, o_switched, o_pv;
  logic [PID_W-1:0] o_pp;
  logic [55:0] out_data;

  logic div_start, div_busy;
  logic [29:0] div_q;
  logic [UTIL_W-1:0] new_util;

  rmts_div u_div (
    .clk(clk),
    .rst(rst),
    .start(div_start),
    .dividend(30'(in_ptime) * 30'(UTIL_SCALE)),
    .divisor(in_period),
    .busy(div_busy),
    .quotient(div_q)
  );

  assign new_util = (div_q > 30'(UTIL_MAX)) ? UTIL_MAX : div_q[UTIL_W-1:0];

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    rd_data <= mem[rd_addr];
  end

  assign s_axis_tready = (state == S_IDLE);

  logic [TIME_W-1:0] adv_deadline;
  logic yield_missed;
  logic reg_go;
  logic admit;
  assign adv_deadline = rd_data.started ?
      rd_data.deadline + TIME_W'(rd_data.period) : now_ticks + TIME_W'(rd_data.period);
  assign yield_missed = rd_data.started && (now_ticks > adv_deadline);
  assign reg_go = (in_period != '0) && !found && free_found;
  assign admit = (util_sum + 19'(new_util)) <= 19'(util_bound);

  always_comb begin
    state_next = state;
    rd_addr = cnt[SW-1:0];
    div_start = 1'b0;
    wr_en = 1'b0;
    wr_addr = found_slot;
    wr_data = '{pid: rd_data.pid, period: rd_data.period, util: rd_data.util,
                deadline: adv_deadline, started: 1'b1};
    unique case (state)
      S_IDLE: if (s_axis_tvalid && s_axis_tready) state_next = S_SCAN_ISSUE;
      S_SCAN_ISSUE: state_next = S_SCAN;
      S_SCAN: if (cnt == CW'(MAX_TASKS)) state_next = S_ACT;
      S_ACT: begin
        rd_addr = found_slot;
        state_next = S_OUT;
        case (act)
          ACT_REGISTER: begin
            if (reg_go) begin
              div_start = 1'b1;
              state_next = S_DIV;
            end
          end
          ACT_TICK: if (woke) state_next = S_DISP_ISSUE;
          default: if (found) state_next = S_PID_RD;
        endcase
      end
      S_PID_RD: begin
        rd_addr = found_slot;
        state_next = S_PID_WAIT;
      end
      S_PID_WAIT: begin
        state_next = S_OUT;
        if (act == ACT_YIELD) begin
          wr_en = 1'b1;
          if (!yield_missed) state_next = S_DISP_ISSUE;
        end else if (running_valid && running_slot == found_slot) begin
          state_next = S_DISP_ISSUE;
        end
      end
      S_DIV: if (!div_busy) state_next = S_REG_DONE;
      S_REG_DONE: begin
        state_next = S_OUT;
        if (admit) begin
          wr_en = 1'b1;
          wr_addr = free_slot;
          wr_data = '{pid: in_pid, period: in_period, util: new_util,
                      deadline: '0, started: 1'b0};
        end
      end
      S_DISP_ISSUE: state_next = S_DISP;
      S_DISP: begin
        if (cnt == CW'(MAX_TASKS)) state_next = S_DISP_RUNRD;
      end
      S_DISP_RUNRD: begin
        rd_addr = running_slot;
        state_next = S_DISP_DECIDE;
      end
      S_DISP_DECIDE: state_next = S_OUT;
      S_OUT: if (!m_axis_tvalid || m_axis_tready) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      slot_valid <= '0;
      timer_armed <= '0;
      util_bound <= BOUND_RESET;
      now_ticks <= '0;
      running_slot <= '0;
      running_valid <= 1'b0;
      running_pid <= '0;
      m_axis_tvalid <= 1'b0;
      out_data <= '0;
      cnt <= '0;
    end else begin
      state <= state_next;
      if (cfg_we) util_bound <= cfg_data;
      if (state == S_OUT && (!m_axis_tvalid || m_axis_tready)) begin
        m_axis_tvalid <= 1'b1;
        out_data <= {5'd0, o_pp, o_pv, o_switched,
                     running_valid ? running_pid : {PID_W{1'b0}},
                     running_valid, o_missed, o_status};
      end else if (m_axis_tvalid && m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (s_axis_tvalid && s_axis_tready) begin
            act <= s_axis_tdata[1:0];
            in_pid <= s_axis_tdata[23:2];
            in_period <= s_axis_tdata[39:24];
            in_ptime <= s_axis_tdata[55:40];
            cnt <= '0;
            found <= 1'b0;
            free_found <= 1'b0;
            util_sum <= '0;
            woke <= 1'b0;
            o_status <= ST_OK;
            o_missed <= 1'b0;
            o_switched <= 1'b0;
            o_pv <= 1'b0;
            o_pp <= '0;
            if (s_axis_tdata[1:0] == ACT_TICK) now_ticks <= now_ticks + 1'b1;
          end
        end
        S_SCAN_ISSUE: begin
          cur <= cnt[SW-1:0];
          cnt <= cnt + 1'b1;
        end
        S_SCAN: begin
          if (slot_valid[cur]) begin
            util_sum <= util_sum + 19'(rd_data.util);
            if (rd_data.pid == in_pid && !found) begin
              found <= 1'b1;
              found_slot <= cur;
            end
            if (act == ACT_TICK && timer_armed[cur] && now_ticks >= rd_data.deadline) begin
              timer_armed[cur] <= 1'b0;
              mode[cur] <= MODE_READY;
              woke <= 1'b1;
            end
          end else if (!free_found) begin
            free_found <= 1'b1;
            free_slot <= cur;
          end
          cur <= cnt[SW-1:0];
          if (cnt != CW'(MAX_TASKS)) cnt <= cnt + 1'b1;
        end
        S_ACT: begin
          case (act)
            ACT_REGISTER: begin
              if (in_period == '0) o_status <= ST_ZERO_PERIOD;
              else if (found) o_status <= ST_DUPLICATE;
              else if (!free_found) o_status <= ST_FULL;
            end
            ACT_TICK: begin
              if (woke) begin
                cnt <= '0;
                best_v <= 1'b0;
              end
            end
            default: begin
              if (!found) o_status <= ST_UNKNOWN;
            end
          endcase
        end
        S_PID_WAIT: begin
          cnt <= '0;
          best_v <= 1'b0;
          if (act == ACT_YIELD) begin
            if (yield_missed) begin
              o_missed <= 1'b1;
            end else begin
              timer_armed[found_slot] <= 1'b1;
              mode[found_slot] <= MODE_SLEEPING;
              running_valid <= 1'b0;
            end
          end else begin
            slot_valid[found_slot] <= 1'b0;
            timer_armed[found_slot] <= 1'b0;
            if (running_valid && running_slot == found_slot) running_valid <= 1'b0;
          end
        end
        S_REG_DONE: begin
          if (!admit) begin
            o_status <= ST_ADMIT_FAIL;
          end else begin
            slot_valid[free_slot] <= 1'b1;
            timer_armed[free_slot] <= 1'b0;
            mode[free_slot] <= MODE_SLEEPING;
          end
        end
        S_DISP_ISSUE: begin
          cur <= cnt[SW-1:0];
          cnt <= cnt + 1'b1;
        end
        S_DISP: begin
          if (slot_valid[cur] && mode[cur] == MODE_READY &&
              (!best_v || rd_data.period < best_period)) begin
            best_v <= 1'b1;
            best <= cur;
            best_period <= rd_data.period;
            best_pid <= rd_data.pid;
          end
          cur <= cnt[SW-1:0];
          if (cnt != CW'(MAX_TASKS)) cnt <= cnt + 1'b1;
        end
        S_DISP_DECIDE: begin
          if (best_v) begin
            if (!running_valid) begin
              mode[best] <= MODE_RUNNING;
              running_slot <= best;
              running_valid <= 1'b1;
              running_pid <= best_pid;
              o_switched <= 1'b1;
            end else if (best_period < rd_data.period) begin
              mode[running_slot] <= MODE_READY;
              o_pv <= 1'b1;
              o_pp <= running_pid;
              mode[best] <= MODE_RUNNING;
              running_slot <= best;
              running_pid <= best_pid;
              o_switched <= 1'b1;
            end
          end
        end
        default: ;
      endcase
    end
  end

  assign m_axis_tdata = out_data;

endmodule
